// ===== rtl/raid6_pq_parity_core_macros.svh =====
// Assertion macros shared by the parity core modules.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef RAID6_PQ_PARITY_CORE_MACROS_SVH
`define RAID6_PQ_PARITY_CORE_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define RPQ_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define RPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rpq_pkg.sv =====
// Shared types, constants and the GF(2^8) multiply-by-x function.
// Used by every module of the parity core except rpq_ram; depends on nothing.
package rpq_pkg;

  localparam int MAX_STRIP_WORDS = 512;
  localparam int OFF_W           = $clog2(MAX_STRIP_WORDS);
  localparam int CNT_W           = OFF_W + 1;
  localparam int WORD_W          = 64;
  localparam int LANES           = WORD_W / 8;
  localparam int STRIPS_W        = 8;
  localparam int WORDS_W         = 10;
  localparam int POLY_W          = 8;
  localparam int CFG_DATA_W      = 10;
  localparam int CFG_IDX_W       = 2;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_STRIPS = 2'd0,
    REG_STRIP_WORDS = 2'd1,
    REG_GF_POLY     = 2'd2
  } cfg_reg_t;

  localparam logic [STRIPS_W-1:0] DATA_STRIPS_RST = 8'd4;
  localparam logic [WORDS_W-1:0]  STRIP_WORDS_RST = 10'd512;
  localparam logic [POLY_W-1:0]   GF_POLY_RST     = 8'h1D;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic [OFF_W-1:0]  off;
    logic              first_strip;
    logic              last_strip;
    logic              last_word;
  } rpq_entry_t;

  // Multiply each byte lane by x in GF(2^8) with the given reduction byte.
  function automatic logic [WORD_W-1:0] times_x(input logic [WORD_W-1:0] w,
                                                input logic [POLY_W-1:0] poly);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < LANES; i++) begin
      r[i*8 +: 8] = {w[i*8 +: 7], 1'b0} ^ (w[i*8+7] ? poly : 8'h00);
    end
    return r;
  endfunction

endpackage

// ===== rtl/rpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the running P and Q words; no package dependency.
module rpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rpq_queue.sv =====
// Short register queue between the front and back of the parity core.
// Depends on rpq_pkg and the assertion macro header.
`include "raid6_pq_parity_core_macros.svh"

module rpq_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rpq_pkg::rpq_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output rpq_pkg::rpq_entry_t head
);

  rpq_pkg::rpq_entry_t               entries [rpq_pkg::QUEUE_DEPTH];
  logic [rpq_pkg::QPTR_W-1:0]        wr_ptr;
  logic [rpq_pkg::QPTR_W-1:0]        rd_ptr;
  logic [rpq_pkg::QCNT_W-1:0]        count;
  logic                              do_push;
  logic                              do_pop;

  assign full       = (count == rpq_pkg::QCNT_W'(rpq_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  `RPQ_ASSERT_HOLDS(a_q_count_bound, count <= rpq_pkg::QCNT_W'(rpq_pkg::QUEUE_DEPTH), "queue count overflow")
  `RPQ_ASSERT_IMPL(a_q_no_push_full, push, !full, "push offered while queue full")
  `RPQ_ASSERT_NEXT(a_q_pop_drains, do_pop && !do_push, count == $past(count) - 1'b1, "pop did not drain")

endmodule

// ===== rtl/rpq_front.sv =====
// Front end: accepts data words, tracks offset and strip index, classifies each word.
// Depends on rpq_pkg.
module rpq_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rpq_pkg::STRIPS_W-1:0]   data_strips,
  input  logic [rpq_pkg::WORDS_W-1:0]    strip_words,
  input  logic                           data_valid,
  input  logic [rpq_pkg::WORD_W-1:0]     data_word,
  output logic                           data_stall,
  output logic                           push,
  output rpq_pkg::rpq_entry_t            push_entry,
  input  logic                           queue_full
);

  logic [rpq_pkg::OFF_W-1:0]    word_offset;
  logic [rpq_pkg::STRIPS_W-1:0] strip_index;
  logic [rpq_pkg::CNT_W-1:0]    off_inc;
  logic [rpq_pkg::WORDS_W-1:0]  words_eff;
  logic [rpq_pkg::STRIPS_W-1:0] strips_eff;
  logic [rpq_pkg::STRIPS_W:0]   strip_inc;
  logic                         last_word;
  logic                         last_strip;

  assign data_stall = queue_full;
  assign push       = data_valid && !queue_full;

  // A zero count acts as one; the offset counter cannot pass the store depth.
  assign words_eff  = (strip_words == '0) ? rpq_pkg::WORDS_W'(1) : strip_words;
  assign strips_eff = (data_strips == '0) ? rpq_pkg::STRIPS_W'(1) : data_strips;
  assign off_inc    = rpq_pkg::CNT_W'(word_offset) + 1'b1;
  assign strip_inc  = {1'b0, strip_index} + 1'b1;
  assign last_word  = (32'(off_inc) >= 32'(words_eff)) ||
                      (32'(off_inc) >= 32'(rpq_pkg::MAX_STRIP_WORDS));
  assign last_strip = (strip_inc >= {1'b0, strips_eff});

  always_comb begin
    push_entry.data        = data_word;
    push_entry.off         = word_offset;
    push_entry.first_strip = (strip_index == '0);
    push_entry.last_strip  = last_strip;
    push_entry.last_word   = last_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_offset <= '0;
      strip_index <= '0;
    end else if (push) begin
      if (last_word) begin
        word_offset <= '0;
        strip_index <= last_strip ? '0 : strip_inc[rpq_pkg::STRIPS_W-1:0];
      end else begin
        word_offset <= off_inc[rpq_pkg::OFF_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/rpq_back.sv =====
// Back end: reads the running P/Q store, folds in the new word, writes back or emits.
// Depends on rpq_pkg, rpq_ram and the assertion macro header.
`include "raid6_pq_parity_core_macros.svh"

module rpq_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rpq_pkg::POLY_W-1:0]    gf_poly,
  input  logic                          head_valid,
  input  rpq_pkg::rpq_entry_t           head,
  output logic                          pop,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [rpq_pkg::WORD_W-1:0]    p_word,
  output logic [rpq_pkg::WORD_W-1:0]    q_word,
  output logic                          stripe_end
);

  localparam int W = rpq_pkg::WORD_W;

  rpq_pkg::rpq_entry_t b_item;
  logic                b_valid;
  logic                fwd;
  logic [W-1:0]        fwd_p;
  logic [W-1:0]        fwd_q;
  logic [2*W-1:0]      rd_data;
  logic [W-1:0]        base_p;
  logic [W-1:0]        base_q;
  logic [W-1:0]        new_p;
  logic [W-1:0]        new_q;
  logic                wr_en;
  logic                out_free;
  logic                b_adv;

  // The store is read as the word leaves the queue; the value arrives with
  // the word in the compute stage. A write to the same offset in that very
  // cycle is forwarded instead, since the RAM returns old data.
  rpq_ram #(
    .WIDTH(2 * W),
    .DEPTH(rpq_pkg::MAX_STRIP_WORDS)
  ) u_store (
    .clk     (clk),
    .we      (wr_en),
    .wr_addr (b_item.off),
    .wr_data ({new_p, new_q}),
    .re      (pop),
    .rd_addr (head.off),
    .rd_data (rd_data)
  );

  assign base_p = fwd ? fwd_p : rd_data[2*W-1:W];
  assign base_q = fwd ? fwd_q : rd_data[W-1:0];
  assign new_p  = b_item.first_strip ? b_item.data : (base_p ^ b_item.data);
  assign new_q  = b_item.first_strip ? b_item.data :
                  (rpq_pkg::times_x(base_q, gf_poly) ^ b_item.data);

  assign out_free = !result_valid || !result_stall;
  assign wr_en    = b_valid && !b_item.last_strip;
  assign b_adv    = b_valid && (!b_item.last_strip || out_free);
  assign pop      = head_valid && (!b_valid || b_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item <= head;
      fwd    <= wr_en && (b_item.off == head.off);
      fwd_p  <= new_p;
      fwd_q  <= new_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_adv && b_item.last_strip) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_item.last_strip) begin
      p_word     <= new_p;
      q_word     <= new_q;
      stripe_end <= b_item.last_word;
    end
  end

  `RPQ_ASSERT_NEXT(a_b_pop_fills, pop, b_valid, "popped word missing from compute stage")
  `RPQ_ASSERT_IMPL(a_b_write_never_stalls, wr_en, b_adv, "store update stalled")
  `RPQ_ASSERT_NEXT(a_b_blocked_holds, b_valid && b_item.last_strip && !out_free, b_valid && $stable(b_item.off), "blocked result lost its word")

endmodule

// ===== rtl/raid6_pq_parity_core.sv =====
// Top level of the RAID-6 P/Q parity core: configuration registers, front, queue, back.
// Depends on rpq_pkg, rpq_front, rpq_queue and rpq_back.
//
//   Channel   Signals                                Direction  Moves
//   data      data_valid, data_stall, data_word      in         one strip word per request
//   result    result_valid, result_stall, p_word,    out        final P/Q word per request
//             q_word, stripe_end
//   config    cfg_we, cfg_index, cfg_data            in         one register write
//
// One data word is taken every cycle while data_stall is low; a word reaches its result through the
// queue entry, the compute stage register with the store read data, and the result register.
// The separate read and write ports of the P/Q store each carry one word per cycle.
// Reset clears the offset and strip counters and restores the register defaults; the
// P/Q store is not cleared, since the first strip of every stripe overwrites it.
// A stalled result holds a last-strip word in the compute stage, the four-entry queue absorbs words
// behind it, and data_stall rises only once that queue is full.
module raid6_pq_parity_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rpq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpq_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              data_valid,
  output logic                              data_stall,
  input  logic [rpq_pkg::WORD_W-1:0]        data_word,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [rpq_pkg::WORD_W-1:0]        p_word,
  output logic [rpq_pkg::WORD_W-1:0]        q_word,
  output logic                              stripe_end
);

  logic [rpq_pkg::STRIPS_W-1:0] data_strips;
  logic [rpq_pkg::WORDS_W-1:0]  strip_words;
  logic [rpq_pkg::POLY_W-1:0]   gf_poly;

  logic                         push;
  rpq_pkg::rpq_entry_t          push_entry;
  logic                         queue_full;
  logic                         pop;
  logic                         head_valid;
  rpq_pkg::rpq_entry_t          head;

  // Configuration registers. Writes to an index past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_strips <= rpq_pkg::DATA_STRIPS_RST;
      strip_words <= rpq_pkg::STRIP_WORDS_RST;
      gf_poly     <= rpq_pkg::GF_POLY_RST;
    end else if (cfg_we) begin
      unique case (rpq_pkg::cfg_reg_t'(cfg_index))
        rpq_pkg::REG_DATA_STRIPS: data_strips <= cfg_data[rpq_pkg::STRIPS_W-1:0];
        rpq_pkg::REG_STRIP_WORDS: strip_words <= cfg_data[rpq_pkg::WORDS_W-1:0];
        rpq_pkg::REG_GF_POLY:     gf_poly     <= cfg_data[rpq_pkg::POLY_W-1:0];
        default: ;
      endcase
    end
  end

  // The front counts offsets and strips and tags each word with its role
  // in the stripe, so the back never needs the counters.
  rpq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .data_strips (data_strips),
    .strip_words (strip_words),
    .data_valid  (data_valid),
    .data_word   (data_word),
    .data_stall  (data_stall),
    .push        (push),
    .push_entry  (push_entry),
    .queue_full  (queue_full)
  );

  rpq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back folds each word into the running P and Q for its offset and
  // either stores the partial result or, on the last strip, hands it out.
  rpq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .gf_poly      (gf_poly),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .p_word       (p_word),
    .q_word       (q_word),
    .stripe_end   (stripe_end)
  );

endmodule

// ===== dv/stripe_parity_pkg.sv =====
// Predictor of the RAID-6 P/Q parity core: running P and Q words per offset.
// Depends on rpq_pkg for widths, register indexes and reset values.
package stripe_parity_pkg;
  import rpq_pkg::*;

  localparam logic [WORD_W-1:0] LANE_LOW7 = 64'h7F7F_7F7F_7F7F_7F7F;
  localparam logic [WORD_W-1:0] LANE_TOP  = 64'h8080_8080_8080_8080;

  typedef struct packed {
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] q;
    logic              last;
  } parity_t;

  class stripe_parity;
    logic [WORD_W-1:0]   p_run [MAX_STRIP_WORDS];
    logic [WORD_W-1:0]   q_run [MAX_STRIP_WORDS];
    bit                  filled [MAX_STRIP_WORDS];
    int unsigned         word_offset;
    int unsigned         strip_index;
    logic [STRIPS_W-1:0] data_strips;
    logic [WORDS_W-1:0]  strip_words;
    logic [POLY_W-1:0]   gf_poly;
    parity_t             parity_due [$];
    int unsigned         mismatches;

    function new();
      word_offset = 0;
      strip_index = 0;
      data_strips = DATA_STRIPS_RST;
      strip_words = STRIP_WORDS_RST;
      gf_poly     = GF_POLY_RST;
      mismatches  = 0;
      foreach (filled[i]) filled[i] = 1'b0;
    endfunction

    function int unsigned eff_words(logic [WORDS_W-1:0] n);
      if (n == 0) return 1;
      if (n > MAX_STRIP_WORDS) return MAX_STRIP_WORDS;
      return n;
    endfunction

    function int unsigned eff_strips();
      return (data_strips == 0) ? 1 : data_strips;
    endfunction

    // A word count may only grow mid-stripe if every offset it will read was stored.
    function bit words_safe(logic [WORDS_W-1:0] n);
      if (strip_index == 0) return 1'b1;
      for (int i = 0; i < eff_words(n); i++) begin
        if (!filled[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_DATA_STRIPS: data_strips = v[STRIPS_W-1:0];
        REG_STRIP_WORDS: strip_words = v[WORDS_W-1:0];
        REG_GF_POLY:     gf_poly     = v[POLY_W-1:0];
        default: ;
      endcase
    endfunction

    // Per-lane doubling in GF(2^8): carry bits select the reduction byte.
    function logic [WORD_W-1:0] mul_x(logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] carry;
      logic [WORD_W-1:0] fold;
      carry = (w & LANE_TOP) >> 7;
      fold  = '0;
      for (int b = 0; b < POLY_W; b++) begin
        if (gf_poly[b]) fold |= carry << b;
      end
      return ((w & LANE_LOW7) << 1) ^ fold;
    endfunction

    function void take_word(logic [WORD_W-1:0] d);
      int unsigned       nw;
      int unsigned       ns;
      int unsigned       off;
      logic [WORD_W-1:0] p;
      logic [WORD_W-1:0] q;
      bit                end_word;
      bit                end_strip;
      nw  = eff_words(strip_words);
      ns  = eff_strips();
      off = word_offset;
      if (off >= MAX_STRIP_WORDS) off = 0;
      if (strip_index == 0) begin
        p = d;
        q = d;
      end else begin
        p = p_run[off] ^ d;
        q = mul_x(q_run[off]) ^ d;
      end
      end_word  = (off + 1 >= nw);
      end_strip = (strip_index + 1 >= ns);
      if (end_strip) begin
        parity_due.push_back('{p: p, q: q, last: end_word});
      end else begin
        p_run[off]  = p;
        q_run[off]  = q;
        filled[off] = 1'b1;
      end
      if (end_word) begin
        word_offset = 0;
        strip_index = end_strip ? 0 : ((strip_index + 1) & 8'hFF);
      end else begin
        word_offset = off + 1;
      end
    endfunction

    function void compare_parity(logic [WORD_W-1:0] p, logic [WORD_W-1:0] q, logic last);
      parity_t want;
      if (parity_due.size() == 0) begin
        $error("parity word arrived with none pending: p %h q %h end %b", p, q, last);
        mismatches++;
        return;
      end
      want = parity_due.pop_front();
      if (p !== want.p) begin
        $error("p_word: expected %h, got %h", want.p, p);
        mismatches++;
      end
      if (q !== want.q) begin
        $error("q_word: expected %h, got %h", want.q, q);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("stripe_end: expected %b, got %b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== dv/raid6_pq_parity_core_tb.sv =====
// Testbench top of the RAID-6 P/Q parity core: drives stripes, checks P, Q and stripe_end.
// Depends on rpq_pkg, stripe_parity_pkg and the raid6_pq_parity_core RTL.
module raid6_pq_parity_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpq_pkg::*;
  import stripe_parity_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int unsigned TOTAL_WORDS   = 2000;
  // Three stages plus the four-entry queue, with margin, for words that leave no result.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  data_valid   = 1'b0;
  logic                  data_stall;
  logic [WORD_W-1:0]     data_word    = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [WORD_W-1:0]     p_word;
  logic [WORD_W-1:0]     q_word;
  logic                  stripe_end;

  stripe_parity stripe = new();

  int unsigned words_sent    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 20;
  int unsigned stall_pct     = 46;
  bit          wide_done     = 1'b0;

  raid6_pq_parity_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_word    (data_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .p_word       (p_word),
    .q_word       (q_word),
    .stripe_end   (stripe_end)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Result side: every accepted request is checked against the oldest pending
  // parity word. The stall for the next cycle is drawn after the sample, so the
  // handshake seen here is the one the core saw at this edge. The same process
  // keeps the cycle count and ends a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && result_valid && !result_stall) begin
      stripe.compare_parity(p_word, q_word, stripe_end);
    end
    result_stall <= ($urandom_range(0, 99) < stall_pct);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Data words: lanes of all zeros, all ones, forced top bits (which exercise the
  // polynomial reduction in every lane) and plain random content.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom} | LANE_TOP;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One request on the data channel. Sender gaps are inserted before the word is
  // offered; once offered, valid and the word hold until the core takes them.
  // The idling profile moves on as the stream progresses: sender idles less than
  // the receiver stalls, then the other way round, then no idling at all.
  task automatic send_word(input logic [WORD_W-1:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_word  <= d;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    stripe.take_word(d);
    words_sent++;
    if (words_sent == TOTAL_WORDS / 3) begin
      send_idle_pct = 46;
      stall_pct     = 20;
    end else if (words_sent == 2 * TOTAL_WORDS / 3) begin
      send_idle_pct = 0;
      stall_pct     = 0;
    end
  endtask

  // Sends words until the stripe in progress closes (or a whole stripe if none is open).
  task automatic finish_stripe();
    do send_word(pick_word());
    while (stripe.word_offset != 0 || stripe.strip_index != 0);
  endtask

  // Quiets the data channel and waits for every pending result, then lets words
  // that produce no result drain out of the pipeline before registers change.
  task automatic drain();
    data_valid <= 1'b0;
    @(posedge clk);
    while (stripe.parity_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    stripe.set_reg(idx, v);
    @(posedge clk);
  endtask

  // New geometry for a run of whole stripes. Zero counts and stray upper bits of
  // the strip count field are included; a very tall stripe of single words is rare.
  task automatic new_setting();
    logic [CFG_DATA_W-1:0] ns;
    logic [CFG_DATA_W-1:0] nw;
    if ($urandom_range(0, 39) == 0) begin
      ns = 10'd255;
      nw = 10'd1;
    end else begin
      ns = CFG_DATA_W'($urandom_range(0, 8));
      nw = CFG_DATA_W'($urandom_range(0, 12));
    end
    ns[9:8] = 2'($urandom_range(0, 3));
    cfg_write(REG_DATA_STRIPS, ns);
    cfg_write(REG_STRIP_WORDS, nw);
    if ($urandom_range(0, 2) != 0) cfg_write(REG_GF_POLY, CFG_DATA_W'($urandom_range(0, 1023)));
  endtask

  // A stripe broken off part way, registers changed while the counters stand
  // mid-stripe, and then the stripe closed under the new setting. The word count
  // is only changed where no later strip would read an offset never stored.
  task automatic broken_stripe();
    int unsigned           total;
    logic [CFG_DATA_W-1:0] nw;
    total = stripe.eff_strips() * stripe.eff_words(stripe.strip_words);
    if (total > 1) repeat ($urandom_range(1, total - 1)) send_word(pick_word());
    drain();
    cfg_write(REG_DATA_STRIPS, CFG_DATA_W'($urandom_range(0, 6)));
    nw = CFG_DATA_W'($urandom_range(0, 12));
    if (stripe.words_safe(nw)) cfg_write(REG_STRIP_WORDS, nw);
    cfg_write(REG_GF_POLY, CFG_DATA_W'($urandom_range(0, 255)));
    finish_stripe();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero strip and word counts both act as one: every word is its own stripe,
    // so P and Q equal the data word. A write to the unused index must be ignored,
    // and a zero polynomial makes the doubling a plain lane shift.
    cfg_write(REG_DATA_STRIPS, 10'd0);
    cfg_write(REG_STRIP_WORDS, 10'd0);
    cfg_write(REG_GF_POLY, 10'h000);
    cfg_write(REG_NONE, 10'h3FF);
    send_word('0);
    send_word('1);
    send_word(LANE_TOP);
    send_word(64'h0123_4567_89AB_CDEF);
    drain();

    // Three strips of two words with an all-ones polynomial and carries in every lane.
    cfg_write(REG_DATA_STRIPS, 10'd3);
    cfg_write(REG_STRIP_WORDS, 10'd2);
    cfg_write(REG_GF_POLY, 10'h0FF);
    send_word(LANE_TOP);
    send_word('1);
    send_word('1);
    send_word(LANE_TOP);
    send_word('0);
    send_word(64'h8000_0000_0000_0001);
    drain();

    // Shrink both counts in the middle of the second strip: the strip closes at
    // once and turns out to be the last one.
    cfg_write(REG_DATA_STRIPS, 10'd3);
    cfg_write(REG_STRIP_WORDS, 10'd4);
    cfg_write(REG_GF_POLY, {2'b00, GF_POLY_RST});
    repeat (6) send_word(pick_word());
    drain();
    cfg_write(REG_DATA_STRIPS, 10'd2);
    cfg_write(REG_STRIP_WORDS, 10'd2);
    cfg_write(REG_GF_POLY, 10'h08E);
    finish_stripe();
    drain();

    // Grow the word count while the first strip is still being written.
    send_word(pick_word());
    drain();
    cfg_write(REG_STRIP_WORDS, 10'd4);
    finish_stripe();

    // Random stripes, mostly whole, some broken off with registers changed mid-way.
    // One single-strip stripe uses an oversized word count that clamps to the
    // largest store depth.
    while (words_sent < TOTAL_WORDS) begin
      drain();
      if (!wide_done && words_sent >= TOTAL_WORDS / 2) begin
        cfg_write(REG_DATA_STRIPS, 10'd1);
        cfg_write(REG_STRIP_WORDS, 10'h3FF);
        finish_stripe();
        wide_done = 1'b1;
      end else begin
        new_setting();
        if ($urandom_range(0, 3) == 0) broken_stripe();
        else repeat ($urandom_range(1, 3)) finish_stripe();
      end
    end

    drain();
    if (stripe.mismatches == 0 && stripe.parity_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
